>>> sv/mspfp_pkg.sv
// Shared types and constants for the MSPv2 frame parser.
package mspfp_pkg;

    localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
    localparam logic [7:0] CHAR_X         = 8'h58;
    localparam logic [7:0] CHAR_LT        = 8'h3C;
    localparam logic [7:0] CRC_POLY       = 8'hD5;
    localparam logic [7:0] CRC_MSB        = 8'h80;
    localparam logic [7:0] MAX_KEEP_RESET = 8'd128;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [15:0] message_id;
        logic [7:0]  flag_byte;
        logic [15:0] payload_length;
        logic        check_status;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } queue_out_t;

endpackage

>>> sv/mspfp_ifs.sv
// Channel interfaces: received byte stream and parser results.
interface mspfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mspfp_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] message_id;
    logic [7:0]  flag_byte;
    logic [15:0] payload_length;
    logic        check_status;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output message_id, output flag_byte, output payload_length,
                    output check_status, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input message_id, input flag_byte, input payload_length,
                    input check_status, output ready);
endinterface

>>> sv/mspfp_front.sv
// Front end: header hunt, field capture, CRC-8 DVB-S2 and result generation.
module mspfp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         max_keep,
    output logic               push,
    output mspfp_pkg::result_t push_data
);
    import mspfp_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT_D  = 4'd0,
        PH_HUNT_X  = 4'd1,
        PH_HUNT_L  = 4'd2,
        PH_FLAG    = 4'd3,
        PH_ID_LO   = 4'd4,
        PH_ID_HI   = 4'd5,
        PH_LEN_LO  = 4'd6,
        PH_LEN_HI  = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CRC     = 4'd9
    } phase_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_MSB) != 8'd0)
                v = (v << 1) ^ CRC_POLY;
            else
                v = v << 1;
        end
        return v;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  flag_reg, flag_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  crc_in;
    logic        emit;
    result_t     res;

    // FLAG restarts the CRC from zero for every frame
    assign crc_in = crc8_update((phase_reg == PH_FLAG) ? 8'd0 : crc_reg, rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        flag_next  = flag_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        res        = '0;
        case (phase_reg)
            PH_HUNT_X:
            begin
                if (rx_byte == CHAR_X)
                    phase_next = PH_HUNT_L;
                else if (rx_byte == CHAR_DOLLAR)
                    phase_next = PH_HUNT_X;
                else
                    phase_next = PH_HUNT_D;
            end
            PH_HUNT_L:
            begin
                if (rx_byte == CHAR_LT)
                    phase_next = PH_FLAG;
                else if (rx_byte == CHAR_DOLLAR)
                    phase_next = PH_HUNT_X;
                else
                    phase_next = PH_HUNT_D;
            end
            PH_FLAG:
            begin
                flag_next  = rx_byte;
                crc_next   = crc_in;
                phase_next = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                id_next    = {8'd0, rx_byte};
                crc_next   = crc_in;
                phase_next = PH_ID_HI;
            end
            PH_ID_HI:
            begin
                id_next    = {rx_byte, id_reg[7:0]};
                crc_next   = crc_in;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, rx_byte};
                crc_next   = crc_in;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next   = {rx_byte, len_reg[7:0]};
                crc_next   = crc_in;
                seen_next  = 16'd0;
                phase_next = ({rx_byte, len_reg[7:0]} == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_in;
                if (seen_reg < {8'd0, max_keep})
                begin
                    emit           = 1'b1;
                    res.kind       = KIND_PAYLOAD;
                    res.data_byte  = rx_byte;
                    res.byte_index = seen_reg[7:0];
                end
                seen_next = seen_reg + 16'd1;
                if (seen_next >= len_reg)
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                emit               = 1'b1;
                res.kind           = KIND_REPORT;
                res.message_id     = id_reg;
                res.flag_byte      = flag_reg;
                res.payload_length = len_reg;
                res.check_status   = (rx_byte != crc_reg);
                phase_next         = PH_HUNT_D;
            end
            default:
            begin
                phase_next = (rx_byte == CHAR_DOLLAR) ? PH_HUNT_X : PH_HUNT_D;
            end
        endcase
    end

    assign push      = accept && emit;
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT_D;
            crc_reg   <= 8'd0;
            id_reg    <= 16'd0;
            len_reg   <= 16'd0;
            flag_reg  <= 8'd0;
            seen_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            flag_reg  <= flag_next;
            seen_reg  <= seen_next;
        end
    end

    // an end report always sends the parser back to the header hunt
    a_report_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.kind == KIND_REPORT) |=> (phase_reg == PH_HUNT_D))
        else $error("report did not return parser to hunt");

    // payload indexes stay below the configured keep count
    a_index_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.kind == KIND_PAYLOAD) |-> (push_data.byte_index < max_keep))
        else $error("payload byte beyond keep count emitted");

endmodule

>>> sv/mspfp_queue.sv
// Short result queue between the parser front end and the output stage.
module mspfp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mspfp_pkg::result_t    push_data,
    output logic                  has_room,
    input  logic                  pop,
    output mspfp_pkg::queue_out_t head
);
    import mspfp_pkg::*;

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign has_room   = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (has_room || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

>>> sv/mspfp_back.sv
// Output stage: registers the queue head onto the result channel.
module mspfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mspfp_pkg::queue_out_t head,
    output logic                  pop,
    mspfp_res_if.source           res
);
    import mspfp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop        = head.valid && (!valid_reg || res.ready);
    assign valid_next = pop || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head.data;
    end

    assign res.valid          = valid_reg;
    assign res.kind           = data_reg.kind;
    assign res.data_byte      = data_reg.data_byte;
    assign res.byte_index     = data_reg.byte_index;
    assign res.message_id     = data_reg.message_id;
    assign res.flag_byte      = data_reg.flag_byte;
    assign res.payload_length = data_reg.payload_length;
    assign res.check_status   = data_reg.check_status;

endmodule

>>> sv/msp_v2_frame_parser_top.sv
// MSPv2 frame parser: header hunt, CRC-8 DVB-S2 check, payload and report output.
//
// rx:  one received serial byte per transaction (valid/ready).
// res: one result per transaction; kind 0 is a kept payload byte with its
//      index, kind 1 is the end-of-frame report (id, flag, length, and
//      check_status 1 on CRC mismatch). Most bytes give no result.
// cfg_we/cfg_wdata: writes max_keep, the number of payload bytes passed on
//      per frame; change it only while the block is idle.
// Throughput: one byte per cycle while rx.ready is high; the CRC and fields
//      update on each accepted byte, so rx.ready stays high unless results back up.
// Results: each result is written into the queue at the edge that accepts its
//      byte, then loaded into the output register that drives res.valid.
// When res stalls, results collect in the queue; rx.ready drops only once
//      the queue is full and rises again as soon as an entry leaves.
// Reset clears the parser to the header hunt, empties the queue, drops
//      res.valid and sets max_keep to 128.
module msp_v2_frame_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    mspfp_rx_if.sink   rx,
    mspfp_res_if.source res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import mspfp_pkg::*;

    logic       max_keep_reg;
    logic [7:0] max_keep_q_reg;
    logic       accept;
    logic       push;
    logic       has_room;
    logic       pop;
    result_t    push_data;
    queue_out_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_keep_q_reg <= MAX_KEEP_RESET;
            max_keep_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            max_keep_q_reg <= cfg_wdata;
            max_keep_reg   <= 1'b1;
        end
    end

    assign rx.ready = has_room;
    assign accept   = rx.valid && has_room;

    mspfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .max_keep  (max_keep_q_reg),
        .push      (push),
        .push_data (push_data)
    );

    mspfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .has_room  (has_room),
        .pop       (pop),
        .head      (head)
    );

    mspfp_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

    // once written, the keep register tracks the last write
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (max_keep_reg && max_keep_q_reg == $past(cfg_wdata)))
        else $error("max_keep write lost");

endmodule

>>> verif/mspfp_tb_pkg.sv
// CRC-8 DVB-S2 byte update shared by the frame builder and the checker.
`timescale 1ns / 100ps

package mspfp_tb_pkg;

    import mspfp_pkg::*;

    // MSB first, start value supplied by the caller
    function automatic logic [7:0] crc8_dvb_s2_step(input logic [7:0] crc,
                                                    input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((acc & CRC_MSB) != 8'h00)
                acc = (acc << 1) ^ CRC_POLY;
            else
                acc = acc << 1;
        end
        return acc;
    endfunction

endpackage

>>> verif/msp_v2_frame_parser_checker.sv
// Channel monitor: predicts parser results from accepted bytes and compares them.
`timescale 1ns / 100ps

module msp_v2_frame_parser_checker (
    input  logic       clk,
    input  logic       rst_n,
    mspfp_rx_if        rx,
    mspfp_res_if       res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         mismatches,
    output int         outstanding
);

    import mspfp_pkg::*;
    import mspfp_tb_pkg::*;

    typedef enum logic [3:0] {
        HUNT_DOLLAR,
        HUNT_X,
        HUNT_LT,
        TAKE_FLAG,
        TAKE_ID_LO,
        TAKE_ID_HI,
        TAKE_LEN_LO,
        TAKE_LEN_HI,
        TAKE_PAYLOAD,
        TAKE_CHECK
    } parse_phase_e;

    parse_phase_e phase;
    logic [7:0]   keep_limit;
    logic [7:0]   run_crc;
    logic [7:0]   frame_flag;
    logic [15:0]  frame_id;
    logic [15:0]  frame_len;
    logic [15:0]  payload_count;
    result_t      due_results[$];

    function automatic string describe(result_t r);
        return $sformatf("kind=%0d data=%02h index=%0d id=%04h flag=%02h length=%0d status=%0d",
                         r.kind, r.data_byte, r.byte_index, r.message_id, r.flag_byte,
                         r.payload_length, r.check_status);
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (phase)
            HUNT_X:
            begin
                phase = (b == CHAR_X) ? HUNT_LT : ((b == CHAR_DOLLAR) ? HUNT_X : HUNT_DOLLAR);
            end
            HUNT_LT:
            begin
                phase = (b == CHAR_LT) ? TAKE_FLAG : ((b == CHAR_DOLLAR) ? HUNT_X : HUNT_DOLLAR);
            end
            TAKE_FLAG:
            begin
                frame_flag = b;
                run_crc    = crc8_dvb_s2_step(8'h00, b);
                phase      = TAKE_ID_LO;
            end
            TAKE_ID_LO:
            begin
                frame_id = {8'h00, b};
                run_crc  = crc8_dvb_s2_step(run_crc, b);
                phase    = TAKE_ID_HI;
            end
            TAKE_ID_HI:
            begin
                frame_id[15:8] = b;
                run_crc        = crc8_dvb_s2_step(run_crc, b);
                phase          = TAKE_LEN_LO;
            end
            TAKE_LEN_LO:
            begin
                frame_len = {8'h00, b};
                run_crc   = crc8_dvb_s2_step(run_crc, b);
                phase     = TAKE_LEN_HI;
            end
            TAKE_LEN_HI:
            begin
                frame_len[15:8] = b;
                run_crc         = crc8_dvb_s2_step(run_crc, b);
                payload_count   = 16'h0000;
                phase           = (frame_len == 16'h0000) ? TAKE_CHECK : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD:
            begin
                run_crc = crc8_dvb_s2_step(run_crc, b);
                if (payload_count < {8'h00, keep_limit})
                begin
                    r.kind       = KIND_PAYLOAD;
                    r.data_byte  = b;
                    r.byte_index = payload_count[7:0];
                    due_results.push_back(r);
                end
                payload_count = payload_count + 16'd1;
                if (payload_count >= frame_len)
                    phase = TAKE_CHECK;
            end
            TAKE_CHECK:
            begin
                r.kind           = KIND_REPORT;
                r.message_id     = frame_id;
                r.flag_byte      = frame_flag;
                r.payload_length = frame_len;
                r.check_status   = (b != run_crc);
                due_results.push_back(r);
                phase = HUNT_DOLLAR;
            end
            default:
            begin
                phase = (b == CHAR_DOLLAR) ? HUNT_X : HUNT_DOLLAR;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            phase         = HUNT_DOLLAR;
            keep_limit    = MAX_KEEP_RESET;
            run_crc       = 8'h00;
            frame_flag    = 8'h00;
            frame_id      = 16'h0000;
            frame_len     = 16'h0000;
            payload_count = 16'h0000;
            due_results.delete();
            mismatches    = 0;
            outstanding  <= 0;
        end
        else
        begin
            // a byte taken at the write edge still sees the old limit
            if (rx.valid && rx.ready)
                parse_byte(rx.rx_byte);
            if (cfg_we)
                keep_limit = cfg_wdata;
            if (res.valid && res.ready)
            begin
                got.kind           = res.kind;
                got.data_byte      = res.data_byte;
                got.byte_index     = res.byte_index;
                got.message_id     = res.message_id;
                got.flag_byte      = res.flag_byte;
                got.payload_length = res.payload_length;
                got.check_status   = res.check_status;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: %s", $realtime, describe(got));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.byte_index !== want.byte_index ||
                        got.message_id !== want.message_id ||
                        got.flag_byte !== want.flag_byte ||
                        got.payload_length !== want.payload_length ||
                        got.check_status !== want.check_status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(got));
                    end
                end
            end
            outstanding <= due_results.size();
        end
    end

endmodule

>>> verif/msp_v2_frame_parser_top_tb.sv
// Top of the frame parser testbench: clock, reset, byte stream, result drain, verdict.
`timescale 1ns / 100ps

module msp_v2_frame_parser_top_tb;

    import mspfp_pkg::*;
    import mspfp_tb_pkg::*;

    localparam int RUN_LIMIT = 4_000_000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         mismatches;
    int         outstanding;
    int         items_sent;
    int         cycle_count;
    bit         gaps_on;

    mspfp_rx_if  rx ();
    mspfp_res_if res ();

    msp_v2_frame_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    msp_v2_frame_parser_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("msp_v2_frame_parser_top verification failed");
        $finish;
    end

    // result side: random stall bursts while gaps are enabled
    initial
    begin
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tracked(input logic [7:0] b, inout logic [7:0] crc);
        send_byte(b);
        crc = crc8_dvb_s2_step(crc, b);
    endtask

    // fill < 0 gives random payload; cut >= 0 abandons the frame after that many bytes
    task automatic send_frame(input logic [7:0] flag, input logic [15:0] id,
                              input logic [15:0] len, input int fill,
                              input bit corrupt, input int cut);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_X);
        send_byte(CHAR_LT);
        send_tracked(flag, crc);
        send_tracked(id[7:0], crc);
        send_tracked(id[15:8], crc);
        send_tracked(len[7:0], crc);
        send_tracked(len[15:8], crc);
        for (int i = 0; i < len; i++)
        begin
            if (i == cut)
                return;
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            send_tracked(b, crc);
        end
        if (corrupt)
            crc = crc ^ 8'($urandom_range(1, 255));
        send_byte(crc);
    endtask

    // stop sending and let every pending transaction drain
    task automatic settle();
        rx.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_keep(input logic [7:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [7:0]  keep_plan [6];
        logic [15:0] frame_len;
        int          pick;
        int          seg_end;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 8'h00;
        rx.valid   <= 1'b0;
        rx.rx_byte <= 8'h00;
        items_sent  = 0;
        gaps_on     = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // noise while hunting, then a header broken after the dollar sign
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_DOLLAR);
        send_byte(8'h61);
        // doubled dollar sign restarts the hunt; empty frame with all-ones flag and id
        send_byte(CHAR_DOLLAR);
        send_frame(8'hFF, 16'hFFFF, 16'h0000, -1, 1'b0, -1);

        // header broken by a dollar sign in the third position, then a frame whose
        // limit drops mid-payload and whose check byte is wrong
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_X);
        crc = 8'h00;
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_X);
        send_byte(CHAR_LT);
        send_tracked(8'h00, crc);
        send_tracked(8'h00, crc);
        send_tracked(8'h00, crc);
        send_tracked(8'h03, crc);
        send_tracked(8'h00, crc);
        send_tracked(8'h00, crc);
        send_tracked(8'hFF, crc);
        write_max_keep(8'd1);
        send_tracked(8'h5A, crc);
        send_byte(~crc);

        keep_plan[0] = 8'd255;
        keep_plan[1] = 8'd0;
        keep_plan[2] = 8'($urandom_range(0, 255));
        keep_plan[3] = 8'd1;
        keep_plan[4] = 8'($urandom_range(0, 255));
        keep_plan[5] = 8'd200;

        for (int seg = 0; seg < 6; seg++)
        begin
            write_max_keep(keep_plan[seg]);
            if (seg == 5)
                gaps_on = 1'b0;
            seg_end = items_sent + 300;
            while (items_sent < seg_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        frame_len = 16'($urandom_range(0, 12));
                    else if (pick < 95)
                        frame_len = 16'($urandom_range(13, 40));
                    else
                        frame_len = 16'($urandom_range(250, 300));
                    send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               frame_len, -1, $urandom_range(0, 5) == 0, -1);
                end
                else if (pick < 80)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end
                else if (pick < 90)
                begin
                    send_byte(CHAR_DOLLAR);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_byte(CHAR_X);
                        b = CHAR_LT;
                        while (b == CHAR_LT) b = 8'($urandom_range(0, 255));
                    end
                    else
                    begin
                        b = CHAR_X;
                        while (b == CHAR_X) b = 8'($urandom_range(0, 255));
                    end
                    if ($urandom_range(0, 3) == 0)
                        b = CHAR_DOLLAR;
                    send_byte(b);
                end
                else
                begin
                    // frame dropped mid-payload: following bytes finish it off
                    frame_len = 16'($urandom_range(1, 12));
                    send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               frame_len, -1, 1'b0,
                               $urandom_range(0, int'(frame_len) - 1));
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("msp_v2_frame_parser_top verification clean");
        else
            $display("msp_v2_frame_parser_top verification failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/mspfp_pkg.sv
sv/mspfp_ifs.sv
sv/mspfp_front.sv
sv/mspfp_queue.sv
sv/mspfp_back.sv
sv/msp_v2_frame_parser_top.sv
verif/mspfp_tb_pkg.sv
verif/msp_v2_frame_parser_checker.sv
verif/msp_v2_frame_parser_top_tb.sv
